// ===== design/jsu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_pkg
// Types, constants and helper functions shared by the JSON string unescape
// front end, command queue and result serializer.
// ----------------------------------------------------------------------------
package jsu_pkg;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_U     = 8'h75;

  localparam logic [15:0] HIGH_MIN = 16'hD800;
  localparam logic [15:0] HIGH_MAX = 16'hDBFF;
  localparam logic [15:0] LOW_MIN  = 16'hDC00;
  localparam logic [15:0] LOW_MAX  = 16'hDFFF;
  localparam logic [20:0] SUPP_BASE = 21'h10000;

  typedef enum logic [2:0] {
    KIND_DATA    = 3'd0,
    KIND_END     = 3'd1,
    KIND_UNTERM  = 3'd2,
    KIND_BAD_ESC = 3'd3,
    KIND_END_HEX = 3'd4,
    KIND_BAD_HEX = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    PH_TEXT   = 3'd0,
    PH_ESC    = 3'd1,
    PH_HEX1   = 3'd2,
    PH_HIGH   = 3'd3,
    PH_HIGHBS = 3'd4,
    PH_HEX2   = 3'd5
  } phase_t;

  // Work for the back end: up to four data bytes, then an optional status result.
  typedef struct packed {
    logic [3:0][7:0] data;
    logic [2:0]      ndata;
    logic            stat_en;
    kind_t           stat_kind;
  } cmd_t;

  typedef struct packed {
    logic [3:0][7:0] data;
    logic [2:0]      n;
  } utf8_t;

  typedef struct packed {
    logic  emit_data;
    logic  emit_stat;
    kind_t kind;
    logic  to_esc;
  } text_cls_t;

  typedef struct packed {
    logic       emit_data;
    logic [7:0] b;
    logic       to_hex;
    logic       bad;
  } esc_cls_t;

  typedef struct packed {
    logic valid;
    logic [3:0] d;
  } hex_t;

  function automatic utf8_t utf8_enc(input logic [20:0] cp);
    utf8_t r;
    r = '0;
    if (cp <= 21'h7F) begin
      r.data[0] = cp[7:0];
      r.n = 3'd1;
    end else if (cp <= 21'h7FF) begin
      r.data[0] = {3'b110, cp[10:6]};
      r.data[1] = {2'b10, cp[5:0]};
      r.n = 3'd2;
    end else if (cp <= 21'hFFFF) begin
      r.data[0] = {4'b1110, cp[15:12]};
      r.data[1] = {2'b10, cp[11:6]};
      r.data[2] = {2'b10, cp[5:0]};
      r.n = 3'd3;
    end else begin
      r.data[0] = {5'b11110, cp[20:18]};
      r.data[1] = {2'b10, cp[17:12]};
      r.data[2] = {2'b10, cp[11:6]};
      r.data[3] = {2'b10, cp[5:0]};
      r.n = 3'd4;
    end
    return r;
  endfunction

  function automatic hex_t hex_digit(input logic [7:0] c);
    hex_t r;
    r = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r.valid = 1'b1;
      r.d = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r.valid = 1'b1;
      r.d = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r.valid = 1'b1;
      r.d = 4'(c - 8'h37);
    end
    return r;
  endfunction

  function automatic text_cls_t text_class(input logic [7:0] c);
    text_cls_t r;
    r = '{emit_data: 1'b0, emit_stat: 1'b0, kind: KIND_DATA, to_esc: 1'b0};
    if (c == CH_NUL) begin
      r.emit_stat = 1'b1;
      r.kind = KIND_UNTERM;
    end else if (c == CH_QUOTE) begin
      r.emit_stat = 1'b1;
      r.kind = KIND_END;
    end else if (c == CH_BSL) begin
      r.to_esc = 1'b1;
    end else begin
      r.emit_data = 1'b1;
    end
    return r;
  endfunction

  function automatic esc_cls_t esc_class(input logic [7:0] c);
    esc_cls_t r;
    r = '{emit_data: 1'b1, b: c, to_hex: 1'b0, bad: 1'b0};
    if (c == CH_QUOTE || c == CH_BSL || c == CH_SLASH) begin
      r.b = c;
    end else if (c == 8'h6E) begin
      r.b = 8'h0A;
    end else if (c == 8'h72) begin
      r.b = 8'h0D;
    end else if (c == 8'h74) begin
      r.b = 8'h09;
    end else if (c == 8'h62) begin
      r.b = 8'h08;
    end else if (c == 8'h66) begin
      r.b = 8'h0C;
    end else if (c == CH_U) begin
      r.emit_data = 1'b0;
      r.to_hex = 1'b1;
    end else begin
      r.emit_data = 1'b0;
      r.bad = 1'b1;
    end
    return r;
  endfunction

endpackage

// ===== design/jsu_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_front
// Accepts string bytes, runs the escape and surrogate state machine and
// turns each accepted byte into at most one command for the result serializer.
// ----------------------------------------------------------------------------
module jsu_front import jsu_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] in_byte,
  output logic       push,
  output cmd_t       cmd
);

  phase_t      phase, phase_next;
  logic [15:0] hex_value, hex_value_next;
  logic [15:0] high_surrogate, high_surrogate_next;
  logic [1:0]  digit_count, digit_count_next;

  hex_t        hx;
  logic [15:0] hex_new;
  text_cls_t   tcls;
  esc_cls_t    ecls;
  utf8_t       enc_hex, enc_high, enc_pair;
  logic [20:0] pair_cp;

  assign hx       = hex_digit(in_byte);
  assign hex_new  = {hex_value[11:0], hx.d};
  assign tcls     = text_class(in_byte);
  assign ecls     = esc_class(in_byte);
  assign pair_cp  = SUPP_BASE + {1'b0, high_surrogate[9:0], hex_new[9:0]};
  assign enc_hex  = utf8_enc({5'd0, hex_new});
  assign enc_high = utf8_enc({5'd0, high_surrogate});
  assign enc_pair = utf8_enc(pair_cp);

  always_comb begin
    phase_next          = phase;
    hex_value_next      = hex_value;
    high_surrogate_next = high_surrogate;
    digit_count_next    = digit_count;
    cmd                 = '{data: '0, ndata: 3'd0, stat_en: 1'b0, stat_kind: KIND_DATA};
    unique case (phase)
      PH_ESC: begin
        phase_next = PH_TEXT;
        if (ecls.emit_data) begin
          cmd.data[0] = ecls.b;
          cmd.ndata = 3'd1;
        end else if (ecls.to_hex) begin
          phase_next = PH_HEX1;
          hex_value_next = '0;
          digit_count_next = '0;
        end else begin
          cmd.stat_en = 1'b1;
          cmd.stat_kind = KIND_BAD_ESC;
        end
      end
      PH_HEX1: begin
        if (in_byte == CH_NUL) begin
          cmd.stat_en = 1'b1;
          cmd.stat_kind = KIND_END_HEX;
        end else if (!hx.valid) begin
          cmd.stat_en = 1'b1;
          cmd.stat_kind = KIND_BAD_HEX;
        end else if (digit_count != 2'd3) begin
          hex_value_next = hex_new;
          digit_count_next = digit_count + 2'd1;
        end else begin
          digit_count_next = '0;
          hex_value_next = '0;
          if (hex_new >= HIGH_MIN && hex_new <= HIGH_MAX) begin
            high_surrogate_next = hex_new;
            phase_next = PH_HIGH;
          end else begin
            cmd.data = enc_hex.data;
            cmd.ndata = enc_hex.n;
            phase_next = PH_TEXT;
          end
        end
      end
      PH_HIGH: begin
        if (in_byte == CH_BSL) begin
          phase_next = PH_HIGHBS;
        end else begin
          cmd.data = enc_high.data;
          cmd.ndata = enc_high.n;
          high_surrogate_next = '0;
          phase_next = PH_TEXT;
          if (tcls.emit_data) begin
            cmd.data[3] = in_byte;
            cmd.ndata = 3'd4;
          end
          cmd.stat_en = tcls.emit_stat;
          cmd.stat_kind = tcls.kind;
        end
      end
      PH_HIGHBS: begin
        if (in_byte == CH_U) begin
          phase_next = PH_HEX2;
          hex_value_next = '0;
          digit_count_next = '0;
        end else begin
          cmd.data = enc_high.data;
          cmd.ndata = enc_high.n;
          high_surrogate_next = '0;
          phase_next = PH_TEXT;
          if (ecls.emit_data) begin
            cmd.data[3] = ecls.b;
            cmd.ndata = 3'd4;
          end else begin
            cmd.stat_en = 1'b1;
            cmd.stat_kind = KIND_BAD_ESC;
          end
        end
      end
      PH_HEX2: begin
        if (in_byte == CH_NUL) begin
          cmd.data = enc_high.data;
          cmd.ndata = enc_high.n;
          cmd.stat_en = 1'b1;
          cmd.stat_kind = KIND_UNTERM;
        end else if (!hx.valid) begin
          cmd.stat_en = 1'b1;
          cmd.stat_kind = KIND_BAD_HEX;
        end else if (digit_count != 2'd3) begin
          hex_value_next = hex_new;
          digit_count_next = digit_count + 2'd1;
        end else begin
          if (hex_new >= LOW_MIN && hex_new <= LOW_MAX) begin
            cmd.data = enc_pair.data;
            cmd.ndata = enc_pair.n;
          end else begin
            cmd.data = enc_high.data;
            cmd.ndata = enc_high.n;
          end
          phase_next = PH_TEXT;
          hex_value_next = '0;
          high_surrogate_next = '0;
          digit_count_next = '0;
        end
      end
      default: begin
        phase_next = tcls.to_esc ? PH_ESC : PH_TEXT;
        if (tcls.emit_data) begin
          cmd.data[0] = in_byte;
          cmd.ndata = 3'd1;
        end
        cmd.stat_en = tcls.emit_stat;
        cmd.stat_kind = tcls.kind;
      end
    endcase
    // Every status result returns the decoder to plain text with cleared state.
    if (cmd.stat_en) begin
      phase_next          = PH_TEXT;
      hex_value_next      = '0;
      high_surrogate_next = '0;
      digit_count_next    = '0;
    end
  end

  assign push = accept && (cmd.ndata != 3'd0 || cmd.stat_en);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_TEXT;
      hex_value      <= '0;
      high_surrogate <= '0;
      digit_count    <= '0;
    end else if (accept) begin
      phase          <= phase_next;
      hex_value      <= hex_value_next;
      high_surrogate <= high_surrogate_next;
      digit_count    <= digit_count_next;
    end
  end

endmodule

// ===== design/jsu_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_queue
// Short register queue of commands between the front end and the
// result serializer.
// ----------------------------------------------------------------------------
module jsu_queue import jsu_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t head,
  output logic empty,
  output logic full
);

  cmd_t           entries [QDEPTH];
  logic [QAW-1:0] wptr, rptr;
  logic [QCW-1:0] count;

  assign head  = entries[rptr];
  assign empty = (count == '0);
  assign full  = (count == QCW'(QDEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (rst) full |-> !push)
    else $error("command pushed into a full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) empty |-> !pop)
    else $error("command popped from an empty queue");
`endif

endmodule

// ===== design/jsu_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_back
// Serializes the queue head into result transactions, one per cycle while
// out_stall is low, and marks the final result of each command.
// ----------------------------------------------------------------------------
module jsu_back import jsu_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cmd_t       head,
  input  logic       empty,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output kind_t      out_kind,
  output logic       last
);

  logic [2:0] idx;
  logic [2:0] total;
  logic       fire;

  assign total     = head.ndata + {2'd0, head.stat_en};
  assign out_valid = !empty;
  assign fire      = out_valid && !out_stall;
  assign last      = (idx == total - 3'd1);
  assign pop       = fire && last;

  always_comb begin
    if (idx < head.ndata) begin
      out_byte = head.data[idx[1:0]];
      out_kind = KIND_DATA;
    end else begin
      out_byte = 8'h00;
      out_kind = head.stat_kind;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (fire) begin
      idx <= last ? 3'd0 : idx + 3'd1;
    end
  end

`ifndef SYNTHESIS
  a_idx_in_range: assert property (@(posedge clk) disable iff (rst) out_valid |-> idx < total)
    else $error("result index past the end of the command");
  a_idx_zero_after_pop: assert property (@(posedge clk) disable iff (rst) pop |=> idx == 3'd0)
    else $error("result index not rewound after a command completed");
`endif

endmodule

// ===== design/json_string_unescape_utf8.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_string_unescape_utf8
// Decodes a JSON string body byte by byte into UTF-8 data bytes and status
// results for the closing quote, end of input and malformed escapes.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake            Payload
// in       input      in_valid / in_stall   in_byte
// out      output     out_valid / out_stall out_byte, kind, last
//
// One input byte is accepted every cycle while the command queue has room.
// Each byte yields zero to four results, delivered one per cycle by the
// serializer while out_stall is low, so the output rate sets the long-run pace for escapes.
// The first result of a byte appears in the cycle after it is accepted when the
// queue is empty, and otherwise follows the results already queued.
// Reset is synchronous and returns the decoder to plain text with an empty queue.
// A stalled output holds its result; in_stall rises only while the queue is full.
module json_string_unescape_utf8 import jsu_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic [2:0] kind,
  output logic       last
);

  logic  accept;
  logic  push, pop, empty, full;
  cmd_t  cmd, head;
  kind_t out_kind;

  assign in_stall = full;
  assign accept   = in_valid && !full;
  assign kind     = out_kind;

  jsu_front u_front (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .in_byte (in_byte),
    .push    (push),
    .cmd     (cmd)
  );

  jsu_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (cmd),
    .pop      (pop),
    .head     (head),
    .empty    (empty),
    .full     (full)
  );

  jsu_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .empty     (empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .out_kind  (out_kind),
    .last      (last)
  );

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the JSON string unescape block. A directed
// run of escapes, surrogate pairs and error cases is followed by random
// string bodies mixing plain bytes, escapes, surrogates and error cases. A byte-level decoder
// in the testbench predicts every UTF-8 byte and status result, and the
// monitor checks each output transaction against the oldest prediction while
// both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
  import jsu_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int RANDOM_ITEMS = 216;
  localparam int IDLE_PCT = 26;

  localparam logic [7:0] CH_N = 8'h6E;
  localparam logic [7:0] CH_R = 8'h72;
  localparam logic [7:0] CH_T = 8'h74;
  localparam logic [7:0] CH_B = 8'h62;
  localparam logic [7:0] CH_F = 8'h66;

  typedef struct packed {
    logic [7:0] b;
    kind_t      k;
    logic       l;
  } utf8_res_t;

  typedef struct packed {
    logic [7:0] b;
    logic       hold;
  } text_byte_t;

  logic       clk;
  logic       rst;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic [2:0] kind;
  logic       last;

  text_byte_t body_q[$];
  utf8_res_t  decoded_q[$];
  utf8_res_t  burst_q[$];

  phase_t      dec_phase = PH_TEXT;
  logic [15:0] hex_acc = '0;
  logic [15:0] high_pend = '0;
  logic [1:0]  hex_cnt = '0;

  int   bytes_taken = 0;
  int   mismatches = 0;
  int   cycles = 0;
  logic calm;

  logic [7:0] esc_chars [8] = '{CH_QUOTE, CH_BSL, CH_SLASH, CH_N, CH_R, CH_T, CH_B, CH_F};

  assign calm = (bytes_taken >= 150) && (bytes_taken < 250);

  json_string_unescape_utf8 dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_byte  (in_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_byte (out_byte),
    .kind     (kind),
    .last     (last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int nibble_of(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    return -1;
  endfunction

  task automatic report(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  // Decoder state and expected results.

  task automatic clear_decoder();
    dec_phase = PH_TEXT;
    hex_acc = '0;
    high_pend = '0;
    hex_cnt = '0;
  endtask

  task automatic add_result(input logic [7:0] b, input kind_t k);
    burst_q.push_back('{b: b, k: k, l: 1'b0});
  endtask

  task automatic add_code_point(input logic [20:0] cp);
    if (cp <= 21'h7F) begin
      add_result(cp[7:0], KIND_DATA);
    end else if (cp <= 21'h7FF) begin
      add_result({3'b110, cp[10:6]}, KIND_DATA);
      add_result({2'b10, cp[5:0]}, KIND_DATA);
    end else if (cp <= 21'hFFFF) begin
      add_result({4'b1110, cp[15:12]}, KIND_DATA);
      add_result({2'b10, cp[11:6]}, KIND_DATA);
      add_result({2'b10, cp[5:0]}, KIND_DATA);
    end else begin
      add_result({5'b11110, cp[20:18]}, KIND_DATA);
      add_result({2'b10, cp[17:12]}, KIND_DATA);
      add_result({2'b10, cp[11:6]}, KIND_DATA);
      add_result({2'b10, cp[5:0]}, KIND_DATA);
    end
  endtask

  task automatic plain_char(input logic [7:0] c);
    if (c == CH_NUL) begin
      clear_decoder();
      add_result(8'h00, KIND_UNTERM);
    end else if (c == CH_QUOTE) begin
      clear_decoder();
      add_result(8'h00, KIND_END);
    end else if (c == CH_BSL) begin
      dec_phase = PH_ESC;
    end else begin
      dec_phase = PH_TEXT;
      add_result(c, KIND_DATA);
    end
  endtask

  task automatic escape_char(input logic [7:0] c);
    dec_phase = PH_TEXT;
    case (c)
      CH_QUOTE, CH_BSL, CH_SLASH: add_result(c, KIND_DATA);
      CH_N: add_result(8'h0A, KIND_DATA);
      CH_R: add_result(8'h0D, KIND_DATA);
      CH_T: add_result(8'h09, KIND_DATA);
      CH_B: add_result(8'h08, KIND_DATA);
      CH_F: add_result(8'h0C, KIND_DATA);
      CH_U: begin
        dec_phase = PH_HEX1;
        hex_acc = '0;
        hex_cnt = '0;
      end
      default: begin
        clear_decoder();
        add_result(8'h00, KIND_BAD_ESC);
      end
    endcase
  endtask

  task automatic decode_text_byte(input logic [7:0] c);
    int          d;
    logic [20:0] cp;
    utf8_res_t   tail;
    burst_q.delete();
    d = nibble_of(c);
    case (dec_phase)
      PH_ESC: escape_char(c);
      PH_HEX1: begin
        if (c == CH_NUL) begin
          clear_decoder();
          add_result(8'h00, KIND_END_HEX);
        end else if (d < 0) begin
          clear_decoder();
          add_result(8'h00, KIND_BAD_HEX);
        end else begin
          hex_acc = {hex_acc[11:0], d[3:0]};
          if (hex_cnt < 2'd3) begin
            hex_cnt++;
          end else begin
            hex_cnt = '0;
            if (hex_acc >= HIGH_MIN && hex_acc <= HIGH_MAX) begin
              high_pend = hex_acc;
              dec_phase = PH_HIGH;
            end else begin
              add_code_point(21'(hex_acc));
              dec_phase = PH_TEXT;
            end
            hex_acc = '0;
          end
        end
      end
      PH_HIGH: begin
        if (c == CH_BSL) begin
          dec_phase = PH_HIGHBS;
        end else begin
          add_code_point(21'(high_pend));
          high_pend = '0;
          plain_char(c);
        end
      end
      PH_HIGHBS: begin
        if (c == CH_U) begin
          dec_phase = PH_HEX2;
          hex_acc = '0;
          hex_cnt = '0;
        end else begin
          add_code_point(21'(high_pend));
          high_pend = '0;
          escape_char(c);
        end
      end
      PH_HEX2: begin
        if (c == CH_NUL) begin
          add_code_point(21'(high_pend));
          clear_decoder();
          add_result(8'h00, KIND_UNTERM);
        end else if (d < 0) begin
          clear_decoder();
          add_result(8'h00, KIND_BAD_HEX);
        end else begin
          hex_acc = {hex_acc[11:0], d[3:0]};
          if (hex_cnt < 2'd3) begin
            hex_cnt++;
          end else begin
            if (hex_acc >= LOW_MIN && hex_acc <= LOW_MAX) begin
              cp = SUPP_BASE + (21'(high_pend - HIGH_MIN) << 10) + 21'(hex_acc - LOW_MIN);
              add_code_point(cp);
            end else begin
              add_code_point(21'(high_pend));
            end
            clear_decoder();
          end
        end
      end
      default: plain_char(c);
    endcase
    if (burst_q.size() > 0) begin
      tail = burst_q.pop_back();
      tail.l = 1'b1;
      burst_q.push_back(tail);
    end
    foreach (burst_q[i]) decoded_q.push_back(burst_q[i]);
  endtask

  // String body generation.

  task automatic feed(input logic [7:0] b, input logic hold = 1'b0);
    body_q.push_back('{b: b, hold: hold});
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return 8'("0") + 8'(n);
    return ($urandom_range(1) ? 8'("a") : 8'("A")) + 8'(n - 4'd10);
  endfunction

  task automatic feed_uesc(input logic [15:0] v);
    feed(CH_BSL);
    feed(CH_U);
    for (int i = 3; i >= 0; i--) feed(hex_char(v[4*i +: 4]));
  endtask

  task automatic feed_udigits(input logic [15:0] v, input int n);
    feed(CH_BSL);
    feed(CH_U);
    for (int i = 0; i < n; i++) feed(hex_char(v[4*(3-i) +: 4]));
  endtask

  function automatic logic [7:0] pick_nonhex();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255)); while (nibble_of(c) >= 0);
    return c;
  endfunction

  function automatic logic [7:0] pick_plain();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255)); while (c == CH_QUOTE || c == CH_BSL);
    return c;
  endfunction

  function automatic logic [7:0] pick_bad_escape();
    logic [7:0] c;
    logic       hit;
    do begin
      c = 8'($urandom_range(0, 255));
      hit = (c == CH_U);
      foreach (esc_chars[i]) if (c == esc_chars[i]) hit = 1'b1;
    end while (hit);
    return c;
  endfunction

  function automatic logic [15:0] pick_high();
    return HIGH_MIN + 16'($urandom_range(0, 16'h3FF));
  endfunction

  function automatic logic [15:0] pick_low();
    return LOW_MIN + 16'($urandom_range(0, 16'h3FF));
  endfunction

  task automatic feed_segment();
    int          sel;
    int          n;
    logic [15:0] v;
    sel = $urandom_range(99);
    if (sel < 30) begin
      n = $urandom_range(1, 4);
      repeat (n) feed(pick_plain());
    end else if (sel < 45) begin
      feed(CH_BSL);
      feed(esc_chars[$urandom_range(7)]);
    end else if (sel < 60) begin
      case ($urandom_range(4))
        0: v = 16'($urandom_range(0, 16'h7F));
        1: v = 16'($urandom_range(16'h80, 16'h7FF));
        2: begin
          v = 16'($urandom_range(16'h800, 16'hFFFF));
          if (v >= HIGH_MIN && v <= HIGH_MAX) v = v ^ 16'h4000;
        end
        3: v = pick_low();
        default: begin
          case ($urandom_range(5))
            0: v = 16'h0000;
            1: v = 16'h007F;
            2: v = 16'h0080;
            3: v = 16'h07FF;
            4: v = 16'h0800;
            default: v = 16'hFFFF;
          endcase
        end
      endcase
      feed_uesc(v);
    end else if (sel < 72) begin
      feed_uesc(pick_high());
      feed_uesc(pick_low());
    end else if (sel < 80) begin
      feed_uesc(pick_high());
      case ($urandom_range(4))
        0: feed(pick_plain());
        1: begin
          feed(CH_BSL);
          feed(esc_chars[$urandom_range(7)]);
        end
        2: begin
          v = 16'($urandom);
          if (v >= LOW_MIN && v <= LOW_MAX) v = v ^ 16'h4000;
          feed_uesc(v);
        end
        3: feed(CH_QUOTE);
        default: begin
          feed(CH_BSL);
          feed(pick_bad_escape());
        end
      endcase
    end else if (sel < 86) begin
      feed($urandom_range(3) == 0 ? CH_NUL : CH_QUOTE);
    end else if (sel < 92) begin
      n = $urandom_range(0, 3);
      v = 16'($urandom);
      case ($urandom_range(4))
        0: begin
          feed(CH_BSL);
          feed(pick_bad_escape());
        end
        1: begin
          feed_udigits(v, n);
          feed(pick_nonhex());
        end
        2: begin
          feed_udigits(v, n);
          feed(CH_NUL);
        end
        3: begin
          feed_uesc(pick_high());
          feed_udigits(v, n);
          feed(CH_NUL);
        end
        default: begin
          feed_uesc(pick_high());
          feed_udigits(v, n);
          feed(pick_nonhex());
        end
      endcase
    end else begin
      n = $urandom_range(1, 3);
      repeat (n) feed(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic feed_directed();
    feed("A");
    feed(8'h01);
    feed(8'h7F);
    feed(8'h80);
    feed(8'hFF);
    foreach (esc_chars[i]) begin
      feed(CH_BSL);
      feed(esc_chars[i]);
    end
    feed_uesc(16'h0000);
    feed_uesc(16'h007F);
    feed_uesc(16'h0080);
    feed_uesc(16'h07FF);
    feed_uesc(16'h0800);
    feed_uesc(16'hFFFF);
    feed_uesc(16'hD800);
    feed_uesc(16'hDC00);
    feed_uesc(16'hDBFF);
    feed_uesc(16'hDFFF);
    feed_uesc(16'hDC00);
    feed_uesc(16'hD834);
    feed("x");
    feed_uesc(16'hD834);
    feed(CH_BSL);
    feed(CH_N);
    feed_uesc(16'hD834);
    feed_uesc(16'h0041);
    feed(CH_QUOTE);
    feed(CH_NUL);
    feed(CH_BSL);
    feed(CH_NUL);
    feed(CH_BSL);
    feed("q");
    feed_udigits(16'h1200, 2);
    feed(CH_NUL);
    feed_udigits(16'h1000, 1);
    feed("G");
    feed_uesc(16'hD800);
    feed_udigits(16'h1000, 1);
    feed(CH_NUL);
    feed_uesc(16'hD800);
    feed_udigits(16'h0000, 0);
    feed("Z");
    feed_uesc(16'hD800);
    feed(CH_QUOTE);
    feed_uesc(16'hDBFF);
    feed(CH_NUL);
  endtask

  // Stimulus, reset and end of run.

  initial begin
    int start;
    rst = 1'b1;
    feed_directed();
    start = body_q.size();
    feed(CH_QUOTE, 1'b1);
    while (body_q.size() - start < RANDOM_ITEMS) begin
      if ($urandom_range(99) < 2) feed("k", 1'b1);
      feed_segment();
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    while (body_q.size() != 0 || in_valid || decoded_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Driver: presents string bytes, holding each until its transaction completes.
  always @(posedge clk) begin
    text_byte_t nxt;
    logic       v_n;
    logic [7:0] b_n;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      v_n = in_valid;
      b_n = in_byte;
      if (in_valid && !in_stall) begin
        decode_text_byte(in_byte);
        bytes_taken++;
        v_n = 1'b0;
      end
      if (!v_n && body_q.size() > 0) begin
        if (body_q[0].hold && decoded_q.size() != 0) begin
          v_n = 1'b0;
        end else if (calm || $urandom_range(99) >= IDLE_PCT) begin
          nxt = body_q.pop_front();
          v_n = 1'b1;
          b_n = nxt.b;
        end
      end
      in_valid <= v_n;
      in_byte <= b_n;
    end
  end

  // Monitor: checks each output transaction against the oldest prediction.
  always @(posedge clk) begin
    utf8_res_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (decoded_q.size() == 0) begin
          report($sformatf("unexpected result byte %02h kind %0d last %0b",
                           out_byte, kind, last));
        end else begin
          want = decoded_q.pop_front();
          if (out_byte !== want.b)
            report($sformatf("out_byte %02h, expected %02h", out_byte, want.b));
          if (kind !== want.k)
            report($sformatf("kind %0d, expected %s", kind, want.k.name()));
          if (last !== want.l)
            report($sformatf("last %0b, expected %0b", last, want.l));
        end
      end
      out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    end
  end

endmodule

// ===== files.f =====
design/jsu_pkg.sv
design/jsu_front.sv
design/jsu_queue.sv
design/jsu_back.sv
design/json_string_unescape_utf8.sv
sim/tb_top.sv
